// ----- hw/rtl/bre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_pkg
// Shared constants, types and controller/datapath handshake structs of the
// bit region engine.
// ----------------------------------------------------------------------------
package bre_pkg;

    // Store geometry
    localparam int MAX_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MAX_BYTES);
    localparam int ULEN_W    = $clog2(MAX_BYTES + 1);
    localparam int BITS_W    = ULEN_W + 3;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 12;
    localparam int DATA_W    = 8;
    localparam int POS_W     = 16;
    localparam int VAL_W     = 16;
    localparam int CFG_W     = 13;

    // Region arithmetic width: holds start + length and the store size in bits
    localparam int EXT_W     = ((BITS_W > POS_W) ? BITS_W : POS_W) + 1;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_USED_BYTES = 1'b0;

    localparam logic [DATA_W-1:0] BYTE_ONES = 8'hFF;
    localparam logic [2:0]        BIT_LAST  = 3'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_BYTE = 3'd0,
        CMD_READ_BYTE  = 3'd1,
        CMD_GET_BIT    = 3'd2,
        CMD_SET        = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_FLIP       = 3'd5,
        CMD_COUNT      = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MODIFY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic decode;
        logic wr_byte;
        logic mem_rd;
        logic step;
        logic clr_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic walk;
        logic direct_write;
        logic last;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- hw/rtl/bre_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_cmd_if
// Command channel: valid/ready handshake with one command item as payload.
// ----------------------------------------------------------------------------
interface bre_cmd_if;
    import bre_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  byte_index;
    logic [DATA_W-1:0] byte_data;
    logic [POS_W-1:0]  bit_start;
    logic [POS_W-1:0]  bit_length;
    logic              lsb_order;

    modport source (
        output valid, cmd, byte_index, byte_data, bit_start, bit_length, lsb_order,
        input  ready
    );

    modport sink (
        input  valid, cmd, byte_index, byte_data, bit_start, bit_length, lsb_order,
        output ready
    );

endinterface

// ----- hw/rtl/bre_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_rsp_if
// Response channel: valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface bre_rsp_if;
    import bre_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             out_of_range;

    modport source (
        output valid, value, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, value, out_of_range,
        output ready
    );

endinterface

// ----- hw/rtl/bit_region_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_region_engine
// Bit string held in a byte store: byte write/read, bit read, region
// set/clear/flip and region popcount, LSB-first or MSB-first per command.
// ----------------------------------------------------------------------------
//
//  channel   direction  protocol        carries
//  i_cmd     in         valid/ready     cmd, byte_index, byte_data, bit_start,
//                                       bit_length, lsb_order
//  o_rsp     out        valid/ready     value, out_of_range
//  APB       in/out     psel/penable    used_bytes at byte address 0
//
//  Steps: accept, decode, then per store byte touched a read state and a
//  modify/write or accumulate state, then the result load. A byte write is
//  done at decode with no walk; byte read and bit read walk one byte, a
//  region each byte it covers; refused or empty commands skip the walk. The
//  registered byte memory read is why each byte has its own read state.
//  Reset: a clearing pass zeroes all 4096 store bytes, one byte a cycle; no
//  command is taken meanwhile, configuration writes are.
//  Stalls: the result register holds a finished transfer while the next
//  command is accepted and worked; only the hand-off waits for o_rsp.ready.
// ----------------------------------------------------------------------------
module bit_region_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bre_cmd_if.sink                            i_cmd,
    bre_rsp_if.source                          o_rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bre_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bre_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bre_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import bre_pkg::*;

    logic [CFG_W-1:0] r_used_bytes;
    logic             cfg_write;
    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;

    // Configuration: one register, written in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_USED_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_bytes <= '0;
        end else if (cfg_write) begin
            r_used_bytes <= pwdata[CFG_W-1:0];
        end
    end

    // Read back the register; unmapped addresses read zero
    assign prdata = (paddr[2] == REG_USED_BYTES) ? APB_DATA_W'(r_used_bytes) : '0;

    // Sequencer: owns the command handshake
    bre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Datapath: store, decode, byte walk and the result register
    bre_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_used_bytes   (r_used_bytes),
        .i_op           (i_cmd.cmd),
        .i_byte_index   (i_cmd.byte_index),
        .i_byte_data    (i_cmd.byte_data),
        .i_bit_start    (i_cmd.bit_start),
        .i_bit_length   (i_cmd.bit_length),
        .i_lsb_order    (i_cmd.lsb_order),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_value        (o_rsp.value),
        .o_out_of_range (o_rsp.out_of_range)
    );

endmodule

// ----- hw/rtl/bre_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_datapath
// Byte store, command registers, range decode, per-byte mask/modify/count
// and the output register.
// ----------------------------------------------------------------------------
module bre_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bre_pkg::t_dp_cmd              i_cmd,
    output bre_pkg::t_dp_status           o_status,
    input  logic [bre_pkg::CFG_W-1:0]     i_used_bytes,
    input  logic [bre_pkg::CMD_W-1:0]     i_op,
    input  logic [bre_pkg::IDX_W-1:0]     i_byte_index,
    input  logic [bre_pkg::DATA_W-1:0]    i_byte_data,
    input  logic [bre_pkg::POS_W-1:0]     i_bit_start,
    input  logic [bre_pkg::POS_W-1:0]     i_bit_length,
    input  logic                          i_lsb_order,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bre_pkg::VAL_W-1:0]     o_value,
    output logic                          o_out_of_range
);
    import bre_pkg::*;

    function automatic logic [DATA_W-1:0] rev8(input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        for (int k = 0; k < DATA_W; k++) begin
            r[k] = d[DATA_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [3:0] pop8(input logic [DATA_W-1:0] d);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < DATA_W; k++) begin
            c = c + 4'(d[k]);
        end
        return c;
    endfunction

    logic [DATA_W-1:0] mem [MAX_BYTES];

    // Command registers
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_bidx;
    logic [DATA_W-1:0] r_bdata;
    logic [POS_W-1:0]  r_start;
    logic [EXT_W-1:0]  r_end;
    logic              r_lsb;

    // Walk state
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_last;
    logic [2:0]        r_hi;
    logic [VAL_W-1:0]  r_acc;
    logic              r_oor;
    logic [DATA_W-1:0] r_rdata;

    // Output register
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_oor;

    // Decode
    logic [ULEN_W-1:0] used;
    logic [EXT_W-1:0]  used_x;
    logic [EXT_W-1:0]  size_bits;
    logic [EXT_W-1:0]  start_x;
    logic [EXT_W-1:0]  cnt_end;
    logic [EXT_W-1:0]  reg_end;
    logic [EXT_W-1:0]  reg_last_bit;
    logic              reg_empty;
    logic              mut_oor;
    logic              idx_ok;
    logic              bit_ok;
    logic              is_mut;
    logic              dec_oor;
    logic              dec_walk;
    logic              dec_write;
    logic [ADDR_W-1:0] dec_addr;
    logic [ADDR_W-1:0] dec_last;

    // Per-byte step
    logic [ADDR_W-1:0] first_addr;
    logic [2:0]        lo;
    logic [2:0]        hi;
    logic [2:0]        bit_pos;
    logic [DATA_W-1:0] lmask;
    logic [DATA_W-1:0] pmask;
    logic [VAL_W:0]    acc_sum;
    logic [DATA_W-1:0] mod_data;
    logic [VAL_W-1:0]  step_val;

    // Memory write port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;

    assign used = (i_used_bytes > CFG_W'(MAX_BYTES)) ? ULEN_W'(MAX_BYTES)
                                                     : ULEN_W'(i_used_bytes);
    assign used_x       = EXT_W'(used);
    assign size_bits    = EXT_W'({used, 3'b000});
    assign start_x      = EXT_W'(r_start);
    assign cnt_end      = (r_end > size_bits) ? size_bits : r_end;
    assign reg_end      = (r_cmd == CMD_COUNT) ? cnt_end : r_end;
    assign reg_empty    = (reg_end <= start_x);
    assign reg_last_bit = reg_end - EXT_W'(1);
    assign mut_oor      = (start_x > size_bits) || (r_end > size_bits);
    assign idx_ok       = (EXT_W'(r_bidx) < used_x);
    assign bit_ok       = (EXT_W'(r_start[POS_W-1:3]) < used_x);
    assign is_mut       = (r_cmd == CMD_SET) || (r_cmd == CMD_CLEAR) || (r_cmd == CMD_FLIP);

    always_comb begin
        dec_oor   = 1'b0;
        dec_walk  = 1'b0;
        dec_write = 1'b0;
        dec_addr  = ADDR_W'(r_start[POS_W-1:3]);
        dec_last  = ADDR_W'(reg_last_bit[EXT_W-1:3]);
        unique case (r_cmd)
            CMD_WRITE_BYTE: begin
                dec_oor   = !idx_ok;
                dec_write = idx_ok;
            end
            CMD_READ_BYTE: begin
                dec_oor  = !idx_ok;
                dec_walk = idx_ok;
                dec_addr = ADDR_W'(r_bidx);
                dec_last = ADDR_W'(r_bidx);
            end
            CMD_GET_BIT: begin
                dec_oor  = !bit_ok;
                dec_walk = bit_ok;
                dec_last = ADDR_W'(r_start[POS_W-1:3]);
            end
            CMD_SET, CMD_CLEAR, CMD_FLIP: begin
                dec_oor  = mut_oor;
                dec_walk = !mut_oor && !reg_empty;
            end
            CMD_COUNT: begin
                dec_walk = !reg_empty;
            end
            default: begin
                dec_oor = 1'b0;
            end
        endcase
    end

    // Mask of the region's bits inside the current byte
    assign first_addr = ADDR_W'(r_start[POS_W-1:3]);
    assign lo       = (r_addr == first_addr) ? r_start[2:0] : 3'd0;
    assign hi       = (r_addr == r_last) ? r_hi : BIT_LAST;
    assign lmask    = (BYTE_ONES << lo) & (BYTE_ONES >> (BIT_LAST - hi));
    assign pmask    = r_lsb ? lmask : rev8(lmask);
    assign bit_pos  = r_lsb ? r_start[2:0] : (BIT_LAST - r_start[2:0]);
    assign acc_sum  = {1'b0, r_acc} + (VAL_W + 1)'(pop8(r_rdata & pmask));

    always_comb begin
        mod_data = r_rdata;
        step_val = r_acc;
        unique case (r_cmd)
            CMD_READ_BYTE: step_val = VAL_W'(r_rdata);
            CMD_GET_BIT:   step_val = VAL_W'(r_rdata[bit_pos]);
            CMD_SET:       mod_data = r_rdata | pmask;
            CMD_CLEAR:     mod_data = r_rdata & ~pmask;
            CMD_FLIP:      mod_data = r_rdata ^ pmask;
            CMD_COUNT:     step_val = acc_sum[VAL_W] ? {VAL_W{1'b1}} : acc_sum[VAL_W-1:0];
            default:       step_val = r_acc;
        endcase
    end

    assign mem_we = i_cmd.clr_step || i_cmd.wr_byte || (i_cmd.step && is_mut);
    assign mem_wa = i_cmd.wr_byte ? ADDR_W'(r_bidx) : r_addr;
    assign mem_wd = i_cmd.clr_step ? '0 : (i_cmd.wr_byte ? r_bdata : mod_data);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(i_op);
            r_bidx  <= i_byte_index;
            r_bdata <= i_byte_data;
            r_start <= i_bit_start;
            r_end   <= EXT_W'(i_bit_start) + EXT_W'(i_bit_length);
            r_lsb   <= i_lsb_order;
        end
        if (i_cmd.decode) begin
            r_hi  <= reg_last_bit[2:0];
            r_acc <= '0;
            r_oor <= dec_oor;
        end else if (i_cmd.step) begin
            r_acc <= step_val;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_acc;
            r_out_oor   <= r_oor;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_last      <= ADDR_W'(MAX_BYTES - 1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.decode) begin
                r_addr <= dec_addr;
                r_last <= dec_last;
            end else if (i_cmd.step || i_cmd.clr_step) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.walk         = dec_walk;
    assign o_status.direct_write = dec_write;
    assign o_status.last         = (r_addr == r_last);
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_out_value;
    assign o_out_of_range = r_out_oor;

endmodule

// ----- hw/rtl/bre_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_ctrl
// Sequencer: clearing pass, command accept, decode, byte walk, result hand-off.
// ----------------------------------------------------------------------------
module bre_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bre_pkg::t_dp_status i_status,
    output bre_pkg::t_dp_cmd    o_cmd
);
    import bre_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_status.last) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: n_state = i_status.walk ? S_READ : S_DONE;
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: if (i_status.last) n_state = S_DONE;
                      else n_state = S_READ;
            S_DONE:   if (!i_status.out_busy) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode  = 1'b1;
                o_cmd.wr_byte = i_status.direct_write;
            end
            S_READ:   o_cmd.mem_rd = 1'b1;
            S_MODIFY: o_cmd.step = 1'b1;
            S_DONE:   o_cmd.out_load = !i_status.out_busy;
            default:  o_cmd = '0;
        endcase
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("reset did not start the clearing pass");

    a_modify_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY) |-> ($past(r_state) == S_READ))
        else $error("byte modify without a preceding read");

    a_decode_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE) |-> $past(o_cmd.load))
        else $error("decode without an accepted command");

    a_result_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

endmodule
